@@ design/cfbs_pkg.sv @@
// shared types and constants for the channel fifo bank with select
package cfbs_pkg;

  // request modes
  localparam logic [2:0] MODE_SEND   = 3'd0;
  localparam logic [2:0] MODE_RECV   = 3'd1;
  localparam logic [2:0] MODE_CLOSE  = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_SELECT = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BLOCK  = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  // field widths fixed by the interface
  localparam int MODE_W  = 3;
  localparam int CHAN_W  = 3;
  localparam int WORD_W  = 32;
  localparam int MASK_W  = 8;
  localparam int CAP_W   = 5;

  // select scans up to eight cases
  localparam int SELECT_SLOTS = 8;

  // configuration register map
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // verdict of the shared channel evaluator
  typedef struct packed {
    logic ok;    // the send or receive can be carried out
    logic live;  // the case may still succeed later
  } eval_t;

endpackage

@@ design/cfbs_word_ram.sv @@
// word memory holding every channel's ring, one write and one registered read port
module cfbs_word_ram
  import cfbs_pkg::*;
#(
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/cfbs_chan_eval.sv @@
// shared evaluator: judges one send or receive case and works out ring positions
module cfbs_chan_eval
  import cfbs_pkg::*;
#(
  parameter int MAX_DEPTH = 16,
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int FW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          present,
  input  logic          closed,
  input  logic          is_send,
  input  logic [PW-1:0] rp,
  input  logic [FW-1:0] fill,
  input  logic [FW-1:0] eff_cap,
  output eval_t         res,
  output logic [PW-1:0] wr_pos,
  output logic [PW-1:0] rp_next
);

  logic [FW:0] sum;
  logic        empty;

  assign empty = (fill == '0);

  // success and liveness of the case
  always_comb begin
    if (is_send) begin
      res.ok   = present && !closed && (fill < eff_cap);
      res.live = present && !closed;
    end else begin
      res.ok   = present && !empty;
      res.live = present && !(closed && empty);
    end
  end

  // tail position: read pointer plus fill, wrapped once at the ring size
  always_comb begin
    sum = (FW+1)'(rp) + (FW+1)'(fill);
    if (sum >= (FW+1)'(MAX_DEPTH)) begin
      sum = sum - (FW+1)'(MAX_DEPTH);
    end
    wr_pos = sum[PW-1:0];
  end

  // head advance after a receive
  assign rp_next = (rp == PW'(MAX_DEPTH - 1)) ? '0 : rp + PW'(1);

endmodule

@@ design/channel_fifo_bank_select_unit.sv @@
// top level: channel fifo bank with try send, try receive, close, query and select
//
//  channel   handshake                   payload
//  request   start / busy                in_mode, in_channel, in_value, in_slot_mask,
//                                        in_dir_mask
//  result    out_valid (one-cycle pulse) out_status, out_data, out_served, out_was_send,
//                                        out_is_closed
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata (capacity at byte 0)
//
// a request is judged in the evaluation state by the shared evaluator and its result is
// registered; a successful receive also passes the read state for the word memory read port.
// a select evaluates one case per cycle and stops at the first of the eight that succeeds.
// busy stays high from the accepting edge until the edge that shows the result.
// reset is synchronous, active low, and empties and opens every channel.
// results cannot be held off; each is shown for exactly one cycle.
module channel_fifo_bank_select_unit
  import cfbs_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CHAN_W-1:0] in_channel,
  input  logic [WORD_W-1:0] in_value,
  input  logic [MASK_W-1:0] in_slot_mask,
  input  logic [MASK_W-1:0] in_dir_mask,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [WORD_W-1:0] out_data,
  output logic [CHAN_W-1:0] out_served,
  output logic              out_was_send,
  output logic              out_is_closed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FW    = $clog2(MAX_DEPTH + 1);
  localparam int WORDS = NUM_CHANNELS * MAX_DEPTH;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [CHAN_W-1:0] LAST_SLOT = CHAN_W'(SELECT_SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_READ} state_t;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [CHAN_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] value_r;
  logic [MASK_W-1:0] slots_r, dirs_r;
  logic              live_r, live_nxt;
  logic [CAP_W-1:0]  cap_r;

  logic [PW-1:0]           rp_r   [NUM_CHANNELS];
  logic [FW-1:0]           fill_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] closed_r;

  logic              out_valid_nxt, was_send_nxt, is_closed_nxt;
  logic [1:0]        status_nxt;
  logic [WORD_W-1:0] data_nxt;
  logic [CHAN_W-1:0] index_nxt;

  logic          accept, cfg_wr;
  logic          cur_present, cur_closed, cur_send, cur_enabled;
  logic [PW-1:0] cur_rp, wr_pos, rp_next;
  logic [FW-1:0] cur_fill, eff_cap;
  eval_t         ev;
  logic          do_write, do_read, do_close;
  logic [AW-1:0] base_addr, waddr, raddr;
  logic [WORD_W-1:0] rdata;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // effective capacity, clamped to one and to the ring size
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = FW'(1);
    end else if (int'(cap_r) > MAX_DEPTH) begin
      eff_cap = FW'(MAX_DEPTH);
    end else begin
      eff_cap = FW'(cap_r);
    end
  end

  // view of the channel under evaluation
  always_comb begin
    cur_rp     = '0;
    cur_fill   = '0;
    cur_closed = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (int'(cur_r) == k) begin
        cur_rp     = rp_r[k];
        cur_fill   = fill_r[k];
        cur_closed = closed_r[k];
      end
    end
  end

  assign cur_present = (int'(cur_r) < NUM_CHANNELS);
  assign cur_enabled = slots_r[cur_r];

  always_comb begin
    case (mode_r)
      MODE_SEND:   cur_send = 1'b1;
      MODE_SELECT: cur_send = dirs_r[cur_r];
      default:     cur_send = 1'b0;
    endcase
  end

  cfbs_chan_eval #(.MAX_DEPTH(MAX_DEPTH)) u_eval (
    .present (cur_present),
    .closed  (cur_closed),
    .is_send (cur_send),
    .rp      (cur_rp),
    .fill    (cur_fill),
    .eff_cap (eff_cap),
    .res     (ev),
    .wr_pos  (wr_pos),
    .rp_next (rp_next)
  );

  // memory actions of the evaluation cycle
  always_comb begin
    do_write = 1'b0;
    do_read  = 1'b0;
    do_close = 1'b0;
    if (state_r == S_EVAL) begin
      case (mode_r)
        MODE_SEND:   do_write = ev.ok;
        MODE_RECV:   do_read  = ev.ok;
        MODE_CLOSE:  do_close = cur_present;
        MODE_SELECT: begin
          do_write = cur_enabled && ev.ok && cur_send;
          do_read  = cur_enabled && ev.ok && !cur_send;
        end
        default: ;
      endcase
    end
  end

  assign base_addr = AW'(int'(cur_r) * MAX_DEPTH);
  assign waddr     = base_addr + AW'(wr_pos);
  assign raddr     = base_addr + AW'(cur_rp);

  cfbs_word_ram #(.DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (waddr),
    .wdata (value_r),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // per-channel pointers, counts and closed flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        rp_r[k]   <= '0;
        fill_r[k] <= '0;
      end
      closed_r <= '0;
    end else begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (int'(cur_r) == k) begin
          if (do_write) begin
            fill_r[k] <= fill_r[k] + FW'(1);
          end
          if (do_read) begin
            fill_r[k] <= fill_r[k] - FW'(1);
            rp_r[k]   <= rp_next;
          end
          if (do_close) begin
            closed_r[k] <= 1'b1;
          end
        end
      end
    end
  end

  // sequencer next state and result
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    data_nxt      = '0;
    index_nxt     = '0;
    was_send_nxt  = 1'b0;
    is_closed_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
          live_nxt  = 1'b0;
          cur_nxt   = (in_mode == MODE_SELECT) ? '0 : in_channel;
        end
      end
      S_EVAL: begin
        case (mode_r)
          MODE_SEND: begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            status_nxt    = ev.ok ? ST_OK : (ev.live ? ST_BLOCK : ST_CLOSED);
          end
          MODE_RECV: begin
            if (ev.ok) begin
              state_nxt = S_READ;
            end else begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              status_nxt    = ev.live ? ST_BLOCK : ST_CLOSED;
            end
          end
          MODE_QUERY: begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            is_closed_nxt = !cur_present || cur_closed;
          end
          MODE_SELECT: begin
            if (cur_enabled && ev.ok) begin
              if (cur_send) begin
                state_nxt     = S_IDLE;
                out_valid_nxt = 1'b1;
                index_nxt     = cur_r;
                was_send_nxt  = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end else begin
              live_nxt = live_r || (cur_enabled && ev.live);
              if (cur_r == LAST_SLOT) begin
                state_nxt     = S_IDLE;
                out_valid_nxt = 1'b1;
                status_nxt    = live_nxt ? ST_BLOCK : ST_CLOSED;
              end else begin
                cur_nxt = cur_r + CHAN_W'(1);
              end
            end
          end
          default: begin
            // close, and unused modes, give an all-zero result
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        data_nxt      = rdata;
        index_nxt     = (mode_r == MODE_SELECT) ? cur_r : '0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
    end
    cur_r         <= cur_nxt;
    live_r        <= live_nxt;
    out_status    <= status_nxt;
    out_data      <= data_nxt;
    out_served    <= index_nxt;
    out_was_send  <= was_send_nxt;
    out_is_closed <= is_closed_nxt;
    if (accept) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      slots_r <= in_slot_mask;
      dirs_r  <= in_dir_mask;
    end
  end

endmodule

@@ design/cfbs_checker.sv @@
// port-level checks on request and result timing, bound to the top level
module cfbs_checker
  import cfbs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [WORD_W-1:0] out_data,
  input logic [CHAN_W-1:0] out_served,
  input logic              out_was_send
);

  // an accepted request makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a result appears only once the block has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // each request ends with its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("request finished without a result");

  // a failed request carries no word, no channel and no send flag
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data == '0 && out_served == '0 && !out_was_send)
    else $error("failed result carries payload");

endmodule

bind channel_fifo_bank_select_unit cfbs_checker u_cfbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_data     (out_data),
  .out_served   (out_served),
  .out_was_send (out_was_send)
);
